/* rtl/stps_pkg.sv */
// ----------------------------------------------------------------------------
// stps_pkg
// Shared types, constants and index helpers for the stereo frame-tag pair
// synchronizer.
// ----------------------------------------------------------------------------
package stps_pkg;

  localparam int FIFO_DEPTH = 8;
  localparam int IDX_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int SUM_W      = CNT_W + 1;

  localparam int STAMP_W = 64;
  localparam int SEQ_W   = 32;
  localparam int SLOP_W  = 32;

  localparam logic [SLOP_W-1:0] SLOP_RESET = 32'd33222591;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic               side;
    logic [STAMP_W-1:0] stamp_ns;
    logic [SEQ_W-1:0]   frame_seq;
  } in_beat_t;

  typedef struct packed {
    logic [SEQ_W-1:0]   left_seq;
    logic [SEQ_W-1:0]   right_seq;
    logic [STAMP_W-1:0] pair_stamp_ns;
  } out_beat_t;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [SEQ_W-1:0]   seq;
  } fifo_entry_t;

  localparam int ENTRY_W = $bits(fifo_entry_t);

  localparam logic SIDE_LEFT  = 1'b0;
  localparam logic SIDE_RIGHT = 1'b1;

  typedef enum logic [1:0] {
    ALU_ORDER,
    ALU_DIFF,
    ALU_SLOP
  } alu_op_t;

  typedef struct packed {
    logic [STAMP_W-1:0] diff;
    logic               borrow;
  } alu_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ORDER,
    ST_DIFF,
    ST_SLOP
  } sync_state_t;

  function automatic idx_t next_idx(input idx_t idx);
    idx_t res;
    if (idx == IDX_W'(FIFO_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = idx + idx_t'(1);
    end
    return res;
  endfunction

  // Head plus count stays below twice the depth, so one subtract wraps it.
  function automatic idx_t slot_idx(input idx_t head, input cnt_t count);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(head) + SUM_W'(count);
    if (sum >= SUM_W'(FIFO_DEPTH)) begin
      sum = sum - SUM_W'(FIFO_DEPTH);
    end
    return IDX_W'(sum);
  endfunction

endpackage

/* rtl/stps_ram.sv */
// ----------------------------------------------------------------------------
// stps_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module stps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/stps_alu.sv */
// ----------------------------------------------------------------------------
// stps_alu
// Shared 64-bit subtractor with borrow, used for the stamp order, the
// absolute stamp difference and the slop compare in turn.
// ----------------------------------------------------------------------------
module stps_alu (
  input  stps_pkg::alu_op_t                 op,
  input  logic [stps_pkg::STAMP_W-1:0]      left_stamp,
  input  logic [stps_pkg::STAMP_W-1:0]      right_stamp,
  input  logic [stps_pkg::STAMP_W-1:0]      diff_in,
  input  logic [stps_pkg::SLOP_W-1:0]       slop,
  input  logic                              left_older,
  output stps_pkg::alu_res_t                res
);

  logic [stps_pkg::STAMP_W-1:0] opa;
  logic [stps_pkg::STAMP_W-1:0] opb;
  logic [stps_pkg::STAMP_W:0]   sub;

  always_comb begin
    case (op)
      stps_pkg::ALU_ORDER: begin
        opa = left_stamp;
        opb = right_stamp;
      end
      stps_pkg::ALU_DIFF: begin
        opa = left_older ? right_stamp : left_stamp;
        opb = left_older ? left_stamp : right_stamp;
      end
      stps_pkg::ALU_SLOP: begin
        opa = diff_in;
        opb = stps_pkg::STAMP_W'(slop);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
    sub        = {1'b0, opa} - {1'b0, opb};
    res.diff   = sub[stps_pkg::STAMP_W-1:0];
    res.borrow = sub[stps_pkg::STAMP_W];
  end

endmodule

/* rtl/stereo_timestamp_pair_sync.sv */
// ----------------------------------------------------------------------------
// stereo_timestamp_pair_sync
// Pairs left and right camera frame tags whose timestamps lie within the
// slop window, using two ring FIFOs and a shared subtract unit.
//
//   channel  ports                        direction  handshake
//   input    start, busy, in_data         in         start & !busy
//   result   out_strobe, out_data         out        out_strobe, one cycle
//   config   cfg_we, cfg_wdata            in         cfg_we
//
// An input beat is taken from idle; then each head compare round steps
// through RAM read, order, difference and slop compare on the shared
// subtractor. There are 0 to FIFO_DEPTH compare rounds; busy stays high
// until the last round pairs or a final check finds one FIFO empty. A
// result appears the cycle after the last round. Reset clears heads and
// counts and loads the slop register with its default window.
// The receiver cannot stall; the FIFO contents need no reset.
// ----------------------------------------------------------------------------
module stereo_timestamp_pair_sync (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  stps_pkg::in_beat_t                in_data,
  output logic                              out_strobe,
  output stps_pkg::out_beat_t               out_data,
  input  logic                              cfg_we,
  input  logic [stps_pkg::SLOP_W-1:0]       cfg_wdata
);

  stps_pkg::sync_state_t state_r, state_nxt;
  stps_pkg::idx_t        lhead_r, lhead_nxt, rhead_r, rhead_nxt;
  stps_pkg::cnt_t        lcount_r, lcount_nxt, rcount_r, rcount_nxt;
  logic                  lt_r, lt_nxt;
  logic [stps_pkg::STAMP_W-1:0] diff_r, diff_nxt;
  logic [stps_pkg::SLOP_W-1:0]  slop_r;
  logic                  out_strobe_r, out_strobe_nxt;
  stps_pkg::out_beat_t   out_data_r, out_data_nxt;

  logic                  accept;
  logic                  lwe, rwe, rd_en;
  stps_pkg::idx_t        lwaddr, rwaddr;
  stps_pkg::fifo_entry_t wentry, lentry, rentry;
  stps_pkg::alu_op_t     alu_op;
  stps_pkg::alu_res_t    alu_res;

  assign accept = start && (state_r == stps_pkg::ST_IDLE);
  assign wentry = '{stamp: in_data.stamp_ns, seq: in_data.frame_seq};

  stps_ram #(
    .WIDTH(stps_pkg::ENTRY_W),
    .DEPTH(stps_pkg::FIFO_DEPTH)
  ) u_left_ram (
    .clk   (clk),
    .we    (lwe),
    .waddr (lwaddr),
    .wdata (wentry),
    .re    (rd_en),
    .raddr (lhead_r),
    .rdata (lentry)
  );

  stps_ram #(
    .WIDTH(stps_pkg::ENTRY_W),
    .DEPTH(stps_pkg::FIFO_DEPTH)
  ) u_right_ram (
    .clk   (clk),
    .we    (rwe),
    .waddr (rwaddr),
    .wdata (wentry),
    .re    (rd_en),
    .raddr (rhead_r),
    .rdata (rentry)
  );

  stps_alu u_alu (
    .op          (alu_op),
    .left_stamp  (lentry.stamp),
    .right_stamp (rentry.stamp),
    .diff_in     (diff_r),
    .slop        (slop_r),
    .left_older  (lt_r),
    .res         (alu_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= stps_pkg::ST_IDLE;
      lhead_r      <= '0;
      rhead_r      <= '0;
      lcount_r     <= '0;
      rcount_r     <= '0;
      slop_r       <= stps_pkg::SLOP_RESET;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      lhead_r      <= lhead_nxt;
      rhead_r      <= rhead_nxt;
      lcount_r     <= lcount_nxt;
      rcount_r     <= rcount_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        slop_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    lt_r       <= lt_nxt;
    diff_r     <= diff_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    lhead_nxt      = lhead_r;
    rhead_nxt      = rhead_r;
    lcount_nxt     = lcount_r;
    rcount_nxt     = rcount_r;
    lt_nxt         = lt_r;
    diff_nxt       = diff_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;
    lwe            = 1'b0;
    rwe            = 1'b0;
    lwaddr         = stps_pkg::slot_idx(lhead_r, lcount_r);
    rwaddr         = stps_pkg::slot_idx(rhead_r, rcount_r);
    rd_en          = 1'b0;
    alu_op         = stps_pkg::ALU_ORDER;

    case (state_r)
      stps_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = stps_pkg::ST_CHECK;
          // A push into a full FIFO overwrites the oldest entry.
          if (in_data.side == stps_pkg::SIDE_LEFT) begin
            lwe = 1'b1;
            if (lcount_r == stps_pkg::cnt_t'(stps_pkg::FIFO_DEPTH)) begin
              lwaddr    = lhead_r;
              lhead_nxt = stps_pkg::next_idx(lhead_r);
            end else begin
              lcount_nxt = lcount_r + stps_pkg::cnt_t'(1);
            end
          end else begin
            rwe = 1'b1;
            if (rcount_r == stps_pkg::cnt_t'(stps_pkg::FIFO_DEPTH)) begin
              rwaddr    = rhead_r;
              rhead_nxt = stps_pkg::next_idx(rhead_r);
            end else begin
              rcount_nxt = rcount_r + stps_pkg::cnt_t'(1);
            end
          end
        end
      end
      stps_pkg::ST_CHECK: begin
        if ((lcount_r != '0) && (rcount_r != '0)) begin
          rd_en     = 1'b1;
          state_nxt = stps_pkg::ST_ORDER;
        end else begin
          state_nxt = stps_pkg::ST_IDLE;
        end
      end
      stps_pkg::ST_ORDER: begin
        alu_op    = stps_pkg::ALU_ORDER;
        lt_nxt    = alu_res.borrow;
        state_nxt = stps_pkg::ST_DIFF;
      end
      stps_pkg::ST_DIFF: begin
        alu_op    = stps_pkg::ALU_DIFF;
        diff_nxt  = alu_res.diff;
        state_nxt = stps_pkg::ST_SLOP;
      end
      stps_pkg::ST_SLOP: begin
        alu_op = stps_pkg::ALU_SLOP;
        if (alu_res.borrow) begin
          out_strobe_nxt             = 1'b1;
          out_data_nxt.left_seq      = lentry.seq;
          out_data_nxt.right_seq     = rentry.seq;
          out_data_nxt.pair_stamp_ns = lt_r ? lentry.stamp : rentry.stamp;
          lhead_nxt  = stps_pkg::next_idx(lhead_r);
          rhead_nxt  = stps_pkg::next_idx(rhead_r);
          lcount_nxt = lcount_r - stps_pkg::cnt_t'(1);
          rcount_nxt = rcount_r - stps_pkg::cnt_t'(1);
          state_nxt  = stps_pkg::ST_IDLE;
        end else begin
          // On equal stamps the right head goes.
          if (lt_r) begin
            lhead_nxt  = stps_pkg::next_idx(lhead_r);
            lcount_nxt = lcount_r - stps_pkg::cnt_t'(1);
          end else begin
            rhead_nxt  = stps_pkg::next_idx(rhead_r);
            rcount_nxt = rcount_r - stps_pkg::cnt_t'(1);
          end
          state_nxt = stps_pkg::ST_CHECK;
        end
      end
      default: begin
        state_nxt = stps_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy       = (state_r != stps_pkg::ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  a_strobe_after_slop: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> ($past(state_r) == stps_pkg::ST_SLOP))
    else $error("result strobe without a slop compare");

  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> !busy)
    else $error("block still busy after a result beat");

  a_compare_both_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == stps_pkg::ST_ORDER) |-> ((lcount_r != '0) && (rcount_r != '0)))
    else $error("head compare with an empty FIFO");

  a_idle_one_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == stps_pkg::ST_IDLE) |-> ((lcount_r == '0) || (rcount_r == '0)))
    else $error("both FIFOs hold entries while idle");

endmodule
